@@ rtl/core/hpes_pkg.sv @@
// Shared constants, state encodings and control types of the heightmap proxy error block.
package hpes_pkg;

  localparam int unsigned STRIDE_BITS = 9;
  localparam int unsigned OFS_BITS    = 8;
  localparam int unsigned WGT_BITS    = 10;
  localparam int unsigned SUM_BITS    = 64;
  localparam int unsigned CNT_BITS    = 32;
  localparam int unsigned NUM_EXTRA   = 12;
  localparam int unsigned MAX_STRIDE  = 256;

  typedef enum logic [2:0] {
    TOP_IDLE,
    TOP_MAC,
    TOP_DIV,
    TOP_DIFF,
    TOP_STAT,
    TOP_OUT
  } hpes_top_e;

  typedef enum logic [1:0] {
    MAC_IDLE,
    MAC_RUN,
    MAC_DONE
  } hpes_mac_e;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_ABS,
    DIV_INIT,
    DIV_ITER,
    DIV_FIX,
    DIV_SAT,
    DIV_DONE
  } hpes_div_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_SQR,
    ST_ACC,
    ST_DONE
  } hpes_st_e;

  typedef struct packed {
    logic start;
    logic restart;
  } hpes_stat_req_t;

endpackage

@@ rtl/core/hpes_mac.sv @@
// Bit-serial weighted sum of the cell corners, one weight bit per cycle, MSB first.
module hpes_mac import hpes_pkg::*; #(
  parameter int unsigned HEIGHT_BITS = 24
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic signed [HEIGHT_BITS-1:0]             a_i,
  input  logic signed [HEIGHT_BITS:0]               d1_i,
  input  logic signed [HEIGHT_BITS:0]               d2_i,
  input  logic        [STRIDE_BITS-1:0]             stride_i,
  input  logic signed [WGT_BITS-1:0]                w1_i,
  input  logic signed [WGT_BITS-1:0]                w2_i,
  output logic signed [HEIGHT_BITS+NUM_EXTRA-1:0]   num_o,
  output logic                                      done_o
);

  localparam int unsigned NW = HEIGHT_BITS + NUM_EXTRA;
  localparam int unsigned CW = $clog2(WGT_BITS);
  localparam logic [CW-1:0] LAST = CW'(WGT_BITS - 1);

  hpes_mac_e             state_q, state_d;
  logic [CW-1:0]         cnt_q;
  logic [HEIGHT_BITS-1:0] a_q;
  logic [HEIGHT_BITS:0]  d1_q, d2_q;
  logic [WGT_BITS-1:0]   sb_q, b1_q, b2_q;
  logic [NW-1:0]         acc_q, acc_d;
  logic [NW-1:0]         ta, t1, t2, inv, base;
  logic                  first;

  always_comb begin
    first = (cnt_q == '0);
    inv   = {NW{first}};
    base  = first ? '0 : (acc_q << 1);
    ta    = sb_q[WGT_BITS-1] ? {{(NW-HEIGHT_BITS){a_q[HEIGHT_BITS-1]}}, a_q} : '0;
    t1    = b1_q[WGT_BITS-1] ? {{(NW-HEIGHT_BITS-1){d1_q[HEIGHT_BITS]}}, d1_q} : '0;
    t2    = b2_q[WGT_BITS-1] ? {{(NW-HEIGHT_BITS-1){d2_q[HEIGHT_BITS]}}, d2_q} : '0;
    acc_d = base + ta + (t1 ^ inv) + (t2 ^ inv) + (first ? NW'(2) : '0);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      MAC_IDLE: begin
        if (start_i) state_d = MAC_RUN;
      end
      MAC_RUN: begin
        if (cnt_q == LAST) state_d = MAC_DONE;
      end
      MAC_DONE: state_d = MAC_IDLE;
      default:  state_d = MAC_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == MAC_DONE);
    num_o  = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MAC_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == MAC_IDLE) begin
        cnt_q <= '0;
      end else if (state_q == MAC_RUN) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MAC_IDLE: begin
        if (start_i) begin
          a_q  <= a_i;
          d1_q <= d1_i;
          d2_q <= d2_i;
          sb_q <= {1'b0, stride_i};
          b1_q <= w1_i;
          b2_q <= w2_i;
        end
      end
      MAC_RUN: begin
        acc_q <= acc_d;
        sb_q  <= sb_q << 1;
        b1_q  <= b1_q << 1;
        b2_q  <= b2_q << 1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/hpes_div.sv @@
// Radix-4 restoring divider by the stride with floor rounding and height saturation.
module hpes_div import hpes_pkg::*; #(
  parameter int unsigned HEIGHT_BITS = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic signed [HEIGHT_BITS+NUM_EXTRA-1:0] num_i,
  input  logic        [STRIDE_BITS-1:0]           stride_i,
  output logic signed [HEIGHT_BITS-1:0]           proxy_o,
  output logic                                    done_o
);

  localparam int unsigned NW    = HEIGHT_BITS + NUM_EXTRA;
  localparam int unsigned HE    = HEIGHT_BITS + (HEIGHT_BITS % 2);
  localparam int unsigned ITERS = HE / 2;
  localparam int unsigned CW    = $clog2(ITERS);
  localparam int unsigned RW    = STRIDE_BITS + 2;
  localparam logic [CW-1:0] LAST = CW'(ITERS - 1);
  localparam logic [HE:0]   QLIM = {{HE{1'b0}}, 1'b1} << (HEIGHT_BITS - 1);
  localparam logic [HEIGHT_BITS-1:0] HMAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
  localparam logic [HEIGHT_BITS-1:0] HMIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

  hpes_div_e              state_q, state_d;
  logic [CW-1:0]          cnt_q;
  logic [NW-1:0]          num_q, mag_q, mag_d;
  logic                   neg_q, ovf_q, ovf_d;
  logic [STRIDE_BITS-1:0] rem_q, rem_d;
  logic [HE-1:0]          quo_q;
  logic [HE:0]            qf_q, qf_d;
  logic [HEIGHT_BITS-1:0] proxy_q, proxy_d;
  logic [RW-1:0]          t, s1, s2, s3, r_sel;
  logic [1:0]             digit;

  always_comb begin
    mag_d = num_q[NW-1] ? (~num_q + NW'(1)) : num_q;
    ovf_d = mag_q[NW-1:HEIGHT_BITS] >= {{(NUM_EXTRA-STRIDE_BITS){1'b0}}, stride_i};

    t  = {rem_q, quo_q[HE-1 -: 2]};
    s1 = {2'b00, stride_i};
    s2 = {1'b0, stride_i, 1'b0};
    s3 = s1 + s2;
    if (t >= s3) begin
      digit = 2'd3;
      r_sel = s3;
    end else if (t >= s2) begin
      digit = 2'd2;
      r_sel = s2;
    end else if (t >= s1) begin
      digit = 2'd1;
      r_sel = s1;
    end else begin
      digit = 2'd0;
      r_sel = '0;
    end
    rem_d = STRIDE_BITS'(t - r_sel);

    qf_d = {1'b0, quo_q} + (HE+1)'(neg_q && (rem_q != '0));

    if (!neg_q) begin
      proxy_d = (ovf_q || (qf_q >= QLIM)) ? HMAX : qf_q[HEIGHT_BITS-1:0];
    end else begin
      proxy_d = (ovf_q || (qf_q > QLIM)) ? HMIN : (~qf_q[HEIGHT_BITS-1:0] + HEIGHT_BITS'(1));
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) state_d = DIV_ABS;
      end
      DIV_ABS:  state_d = DIV_INIT;
      DIV_INIT: state_d = DIV_ITER;
      DIV_ITER: begin
        if (cnt_q == LAST) state_d = DIV_FIX;
      end
      DIV_FIX:  state_d = DIV_SAT;
      DIV_SAT:  state_d = DIV_DONE;
      DIV_DONE: state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    done_o  = (state_q == DIV_DONE);
    proxy_o = proxy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_ITER) begin
        cnt_q <= cnt_q + CW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      DIV_IDLE: begin
        if (start_i) num_q <= num_i;
      end
      DIV_ABS: begin
        mag_q <= mag_d;
        neg_q <= num_q[NW-1];
      end
      DIV_INIT: begin
        ovf_q <= ovf_d;
        rem_q <= mag_q[HE +: STRIDE_BITS];
        quo_q <= mag_q[HE-1:0];
      end
      DIV_ITER: begin
        rem_q <= rem_d;
        quo_q <= {quo_q[HE-3:0], digit};
      end
      DIV_FIX:  qf_q    <= qf_d;
      DIV_SAT:  proxy_q <= proxy_d;
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/hpes_stats.sv @@
// Absolute error, its square and the running error statistics.
module hpes_stats import hpes_pkg::*; #(
  parameter int unsigned HEIGHT_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hpes_stat_req_t                req_i,
  input  logic signed [HEIGHT_BITS:0]   diff_i,
  output logic [HEIGHT_BITS-1:0]        err_o,
  output logic [HEIGHT_BITS-1:0]        peak_o,
  output logic [SUM_BITS-1:0]           total_o,
  output logic [CNT_BITS-1:0]           count_o,
  output logic                          done_o
);

  hpes_st_e                 state_q, state_d;
  logic [HEIGHT_BITS:0]     diff_q, mag;
  logic                     restart_q;
  logic [HEIGHT_BITS-1:0]   err_q;
  logic [2*HEIGHT_BITS-1:0] prod;
  logic [SUM_BITS-1:0]      sq_q;
  logic [SUM_BITS-1:0]      tot_q, tot_d, base_tot;
  logic [SUM_BITS:0]        sum;
  logic [HEIGHT_BITS-1:0]   peak_q, peak_d, base_peak;
  logic [CNT_BITS-1:0]      cnt_q, cnt_d, base_cnt;

  always_comb begin
    mag       = diff_q[HEIGHT_BITS] ? (~diff_q + (HEIGHT_BITS+1)'(1)) : diff_q;
    prod      = {{HEIGHT_BITS{1'b0}}, err_q} * {{HEIGHT_BITS{1'b0}}, err_q};
    base_tot  = restart_q ? '0 : tot_q;
    base_peak = restart_q ? '0 : peak_q;
    base_cnt  = restart_q ? '0 : cnt_q;
    sum       = {1'b0, base_tot} + {1'b0, sq_q};
    tot_d     = sum[SUM_BITS] ? '1 : sum[SUM_BITS-1:0];
    peak_d    = (err_q > base_peak) ? err_q : base_peak;
    cnt_d     = (&base_cnt) ? base_cnt : base_cnt + CNT_BITS'(1);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) state_d = ST_ABS;
      end
      ST_ABS:  state_d = ST_SQR;
      ST_SQR:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    done_o  = (state_q == ST_DONE);
    err_o   = err_q;
    peak_o  = peak_q;
    total_o = tot_q;
    count_o = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tot_q   <= '0;
      peak_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        tot_q  <= tot_d;
        peak_q <= peak_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          diff_q    <= diff_i;
          restart_q <= req_i.restart;
        end
      end
      ST_ABS:  err_q <= mag[HEIGHT_BITS-1:0];
      ST_SQR:  sq_q  <= SUM_BITS'(prod);
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/heightmap_proxy_error_stats.sv @@
// Top level of the heightmap proxy error block: sequencing, stride register and output word.
//
// Each input word is one fine terrain sample; the block interpolates its height over the lower
// or upper triangle of its coarse cell, floors the weighted sum divided by the stride, and
// returns the proxy height, the absolute error and the running peak error, squared-error sum
// and sample count. One word is in flight at a time; from its acceptance until its result is
// loaded, a bit-serial multiply-accumulate walks the ten weight bits, then a radix-4 divider
// produces two quotient bits per cycle. The output register frees the input side as soon as a
// result is loaded, so the next word proceeds while the previous result waits to be taken.
// Write cell_stride only while the block is idle; zero reads as one and values above MAX_STRIDE
// are clamped.
module heightmap_proxy_error_stats import hpes_pkg::*; #(
  parameter int unsigned HEIGHT_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [STRIDE_BITS-1:0]        cfg_cell_stride_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [HEIGHT_BITS-1:0] true_height_i,
  input  logic signed [HEIGHT_BITS-1:0] corner_00_i,
  input  logic signed [HEIGHT_BITS-1:0] corner_10_i,
  input  logic signed [HEIGHT_BITS-1:0] corner_01_i,
  input  logic signed [HEIGHT_BITS-1:0] corner_11_i,
  input  logic [OFS_BITS-1:0]           offset_x_i,
  input  logic [OFS_BITS-1:0]           offset_z_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [HEIGHT_BITS-1:0] proxy_value_o,
  output logic [HEIGHT_BITS-1:0]        abs_error_o,
  output logic                          upper_triangle_o,
  output logic [HEIGHT_BITS-1:0]        max_error_o,
  output logic [SUM_BITS-1:0]           squared_sum_o,
  output logic [CNT_BITS-1:0]           sample_count_o
);

  localparam int unsigned NW = HEIGHT_BITS + NUM_EXTRA;

  hpes_top_e              state_q, state_d;
  logic [STRIDE_BITS-1:0] stride_q, stride_d;
  logic                   in_acc, cfg_acc, out_load;
  logic                   mac_done, div_done, st_done;
  hpes_stat_req_t         st_req;

  logic [HEIGHT_BITS-1:0] th_q;
  logic                   upper_q, restart_q;
  logic [HEIGHT_BITS:0]   diff_q;

  logic [HEIGHT_BITS:0]   c00x, c10x, c01x, c11x;
  logic                   upper_d;
  logic signed [HEIGHT_BITS-1:0] op_a;
  logic signed [HEIGHT_BITS:0]   op_d1, op_d2;
  logic signed [WGT_BITS-1:0]    op_w1, op_w2;
  logic signed [NW-1:0]          num;
  logic signed [HEIGHT_BITS-1:0] proxy;

  logic [HEIGHT_BITS-1:0] err, peak;
  logic [SUM_BITS-1:0]    total;
  logic [CNT_BITS-1:0]    count;

  logic                   out_valid_q;
  logic [HEIGHT_BITS-1:0] out_proxy_q, out_err_q, out_peak_q;
  logic                   out_upper_q;
  logic [SUM_BITS-1:0]    out_total_q;
  logic [CNT_BITS-1:0]    out_count_q;

  always_comb begin
    if (cfg_cell_stride_i == '0) begin
      stride_d = STRIDE_BITS'(1);
    end else if (32'(cfg_cell_stride_i) > MAX_STRIDE) begin
      stride_d = STRIDE_BITS'(MAX_STRIDE);
    end else begin
      stride_d = cfg_cell_stride_i;
    end
  end

  always_comb begin
    c00x    = {corner_00_i[HEIGHT_BITS-1], corner_00_i};
    c10x    = {corner_10_i[HEIGHT_BITS-1], corner_10_i};
    c01x    = {corner_01_i[HEIGHT_BITS-1], corner_01_i};
    c11x    = {corner_11_i[HEIGHT_BITS-1], corner_11_i};
    upper_d = ({2'b00, offset_x_i} + {2'b00, offset_z_i}) > {1'b0, stride_q};
    if (upper_d) begin
      op_a  = corner_11_i;
      op_d1 = c10x - c11x;
      op_d2 = c01x - c11x;
      op_w1 = {1'b0, stride_q} - {2'b00, offset_z_i};
      op_w2 = {1'b0, stride_q} - {2'b00, offset_x_i};
    end else begin
      op_a  = corner_00_i;
      op_d1 = c10x - c00x;
      op_d2 = c01x - c00x;
      op_w1 = {2'b00, offset_x_i};
      op_w2 = {2'b00, offset_z_i};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      TOP_IDLE: begin
        if (in_acc) state_d = TOP_MAC;
      end
      TOP_MAC: begin
        if (mac_done) state_d = TOP_DIV;
      end
      TOP_DIV: begin
        if (div_done) state_d = TOP_DIFF;
      end
      TOP_DIFF: state_d = TOP_STAT;
      TOP_STAT: begin
        if (st_done) state_d = TOP_OUT;
      end
      TOP_OUT: begin
        if (out_load) state_d = TOP_IDLE;
      end
      default: state_d = TOP_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = (state_q != TOP_IDLE);
    cfg_ready_o    = (state_q == TOP_IDLE);
    in_acc         = in_valid_i && (state_q == TOP_IDLE);
    cfg_acc        = cfg_valid_i && (state_q == TOP_IDLE);
    st_req.start   = (state_q == TOP_DIFF);
    st_req.restart = restart_q;
    out_load       = (state_q == TOP_OUT) && (!out_valid_q || !out_stall_i);
  end

  hpes_mac #(
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .a_i     (op_a),
    .d1_i    (op_d1),
    .d2_i    (op_d2),
    .stride_i(stride_q),
    .w1_i    (op_w1),
    .w2_i    (op_w2),
    .num_o   (num),
    .done_o  (mac_done)
  );

  hpes_div #(
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_done),
    .num_i   (num),
    .stride_i(stride_q),
    .proxy_o (proxy),
    .done_o  (div_done)
  );

  hpes_stats #(
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (st_req),
    .diff_i (diff_q),
    .err_o  (err),
    .peak_o (peak),
    .total_o(total),
    .count_o(count),
    .done_o (st_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_IDLE;
      stride_q    <= STRIDE_BITS'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) stride_q <= stride_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      th_q      <= true_height_i;
      upper_q   <= upper_d;
      restart_q <= restart_i;
    end
    if (div_done) begin
      diff_q <= {th_q[HEIGHT_BITS-1], th_q} - {proxy[HEIGHT_BITS-1], proxy};
    end
    if (out_load) begin
      out_proxy_q <= proxy;
      out_err_q   <= err;
      out_upper_q <= upper_q;
      out_peak_q  <= peak;
      out_total_q <= total;
      out_count_q <= count;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign proxy_value_o    = out_proxy_q;
  assign abs_error_o      = out_err_q;
  assign upper_triangle_o = out_upper_q;
  assign max_error_o      = out_peak_q;
  assign squared_sum_o    = out_total_q;
  assign sample_count_o   = out_count_q;

endmodule

@@ rtl/core/hpes_checker.sv @@
// Port-level checks of the heightmap proxy error block and their binding to the top level.
module hpes_checker import hpes_pkg::*; #(
  parameter int unsigned HEIGHT_BITS = 24
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [HEIGHT_BITS-1:0] proxy_value_o,
  input logic [HEIGHT_BITS-1:0]        abs_error_o,
  input logic [HEIGHT_BITS-1:0]        max_error_o,
  input logic [SUM_BITS-1:0]           squared_sum_o,
  input logic [CNT_BITS-1:0]           sample_count_o
);

  property p_busy_after_accept;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && !in_stall_o) |=> in_stall_o;
  endproperty
  a_busy_after_accept: assert property (p_busy_after_accept)
    else $error("input taken while a word is in flight");

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(proxy_value_o)
                                        && $stable(squared_sum_o));
  endproperty
  a_out_hold: assert property (p_out_hold)
    else $error("stalled result word changed");

  property p_peak_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (abs_error_o <= max_error_o) && (sample_count_o != '0);
  endproperty
  a_peak_bound: assert property (p_peak_bound)
    else $error("peak error below current error or zero count");

  property p_first_sample;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && (sample_count_o == CNT_BITS'(1))) |->
        (max_error_o == abs_error_o)
        && (squared_sum_o == SUM_BITS'(abs_error_o) * SUM_BITS'(abs_error_o));
  endproperty
  a_first_sample: assert property (p_first_sample)
    else $error("statistics not restarted from first sample");

endmodule

bind heightmap_proxy_error_stats hpes_checker #(
  .HEIGHT_BITS(HEIGHT_BITS)
) u_hpes_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .proxy_value_o (proxy_value_o),
  .abs_error_o   (abs_error_o),
  .max_error_o   (max_error_o),
  .squared_sum_o (squared_sum_o),
  .sample_count_o(sample_count_o)
);

@@ verif/heightmap_proxy_error_stats_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard of the heightmap proxy error block: predicts every output word and compares it.
module heightmap_proxy_error_stats_checker import hpes_pkg::*; #(
  parameter int unsigned HEIGHT_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [STRIDE_BITS-1:0]        cfg_cell_stride_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [HEIGHT_BITS-1:0] true_height_i,
  input  logic signed [HEIGHT_BITS-1:0] corner_00_i,
  input  logic signed [HEIGHT_BITS-1:0] corner_10_i,
  input  logic signed [HEIGHT_BITS-1:0] corner_01_i,
  input  logic signed [HEIGHT_BITS-1:0] corner_11_i,
  input  logic [OFS_BITS-1:0]           offset_x_i,
  input  logic [OFS_BITS-1:0]           offset_z_i,
  input  logic                          restart_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic signed [HEIGHT_BITS-1:0] proxy_value_i,
  input  logic [HEIGHT_BITS-1:0]        abs_error_i,
  input  logic                          upper_triangle_i,
  input  logic [HEIGHT_BITS-1:0]        max_error_i,
  input  logic [SUM_BITS-1:0]           squared_sum_i,
  input  logic [CNT_BITS-1:0]           sample_count_i,
  output int                            pending_o,
  output int                            fail_count_o,
  output int                            result_count_o
);

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] proxy;
    logic [HEIGHT_BITS-1:0]        abs_err;
    logic                          upper;
    logic [HEIGHT_BITS-1:0]        peak;
    logic [SUM_BITS-1:0]           sq_sum;
    logic [CNT_BITS-1:0]           count;
  } stats_word_t;

  localparam longint HMAX  = (longint'(1) <<< (HEIGHT_BITS - 1)) - 1;
  localparam longint HMASK = (longint'(1) <<< HEIGHT_BITS) - 1;

  logic [STRIDE_BITS-1:0] stride_q;
  logic [SUM_BITS-1:0]    sq_total;
  logic [HEIGHT_BITS-1:0] peak_err;
  logic [CNT_BITS-1:0]    seen_cnt;
  stats_word_t            stats_q[$];
  int                     report_cnt;

  task automatic interpolate_sample();
    longint s, dx, dz, th, c00, c10, c01, c11, num, q, diff, mag;
    logic [SUM_BITS-1:0] sq;
    stats_word_t w;
    s = longint'(stride_q);
    if (s < 1) s = 1;
    if (s > longint'(MAX_STRIDE)) s = longint'(MAX_STRIDE);
    th  = true_height_i;
    c00 = corner_00_i;
    c10 = corner_10_i;
    c01 = corner_01_i;
    c11 = corner_11_i;
    dx  = offset_x_i;
    dz  = offset_z_i;
    w.upper = (dx + dz) > s;
    if (!w.upper) num = c00 * s + dx * (c10 - c00) + dz * (c01 - c00);
    else num = c11 * s + (s - dz) * (c10 - c11) + (s - dx) * (c01 - c11);
    q = num / s;
    if ((num % s) != 0 && num < 0) q = q - 1;
    if (q > HMAX) q = HMAX;
    if (q < -HMAX - 1) q = -HMAX - 1;
    diff = th - q;
    mag = (diff < 0) ? -diff : diff;
    if (mag > HMASK) mag = HMASK;
    if (restart_i) begin
      sq_total = '0;
      peak_err = '0;
      seen_cnt = '0;
    end
    sq = SUM_BITS'(mag) * SUM_BITS'(mag);
    if (sq_total > ~sq) sq_total = '1;
    else sq_total = sq_total + sq;
    if (HEIGHT_BITS'(mag) > peak_err) peak_err = HEIGHT_BITS'(mag);
    if (seen_cnt != '1) seen_cnt = seen_cnt + 1'b1;
    w.proxy   = HEIGHT_BITS'(q);
    w.abs_err = HEIGHT_BITS'(mag);
    w.peak    = peak_err;
    w.sq_sum  = sq_total;
    w.count   = seen_cnt;
    stats_q = {stats_q, w};
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      fail_count_o++;
      if (report_cnt < 10)
        $display("word %0d: %s mismatch, expected %0h, got %0h", result_count_o, name, want, got);
      report_cnt++;
    end
  endtask

  task automatic compare_word();
    stats_word_t w;
    result_count_o++;
    if (stats_q.size() == 0) begin
      fail_count_o++;
      if (report_cnt < 10) $display("word %0d: output with no sample outstanding", result_count_o);
      report_cnt++;
      return;
    end
    w = stats_q.pop_front();
    check_field("proxy_value", w.proxy, proxy_value_i);
    check_field("abs_error", w.abs_err, abs_error_i);
    check_field("upper_triangle", w.upper, upper_triangle_i);
    check_field("max_error", w.peak, max_error_i);
    check_field("squared_sum", w.sq_sum, squared_sum_i);
    check_field("sample_count", w.count, sample_count_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q = 9'd1;
      sq_total = '0;
      peak_err = '0;
      seen_cnt = '0;
      stats_q.delete();
      report_cnt = 0;
      pending_o = 0;
      fail_count_o = 0;
      result_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) compare_word();
      if (cfg_valid_i && cfg_ready_i) stride_q = cfg_cell_stride_i;
      if (in_valid_i && !in_stall_i) interpolate_sample();
      pending_o = stats_q.size();
    end
  end

endmodule

@@ verif/heightmap_proxy_error_stats_tb.sv @@
`timescale 1ns / 100ps
// Testbench top of the heightmap proxy error block: clock, reset, stimulus and verdict.
module heightmap_proxy_error_stats_tb import hpes_pkg::*;;

  localparam int unsigned HB = 24;
  localparam logic signed [HB-1:0] H_MAX = {1'b0, {(HB-1){1'b1}}};
  localparam logic signed [HB-1:0] H_MIN = {1'b1, {(HB-1){1'b0}}};

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [STRIDE_BITS-1:0] cfg_stride = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [HB-1:0]   true_height = '0;
  logic signed [HB-1:0]   corner_00 = '0;
  logic signed [HB-1:0]   corner_10 = '0;
  logic signed [HB-1:0]   corner_01 = '0;
  logic signed [HB-1:0]   corner_11 = '0;
  logic [OFS_BITS-1:0]    offset_x = '0;
  logic [OFS_BITS-1:0]    offset_z = '0;
  logic                   restart = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [HB-1:0]   proxy_value;
  logic [HB-1:0]          abs_error;
  logic                   upper_triangle;
  logic [HB-1:0]          max_error;
  logic [SUM_BITS-1:0]    squared_sum;
  logic [CNT_BITS-1:0]    sample_count;

  int pending, fail_count, result_count;
  int burst_left = 0;
  int gap_max = 0;
  int sent = 0;
  int settings = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int mode_left = 0;

  heightmap_proxy_error_stats #(.HEIGHT_BITS(HB)) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_cell_stride_i(cfg_stride),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .true_height_i    (true_height),
    .corner_00_i      (corner_00),
    .corner_10_i      (corner_10),
    .corner_01_i      (corner_01),
    .corner_11_i      (corner_11),
    .offset_x_i       (offset_x),
    .offset_z_i       (offset_z),
    .restart_i        (restart),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .proxy_value_o    (proxy_value),
    .abs_error_o      (abs_error),
    .upper_triangle_o (upper_triangle),
    .max_error_o      (max_error),
    .squared_sum_o    (squared_sum),
    .sample_count_o   (sample_count)
  );

  heightmap_proxy_error_stats_checker #(.HEIGHT_BITS(HB)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_cell_stride_i(cfg_stride),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .true_height_i    (true_height),
    .corner_00_i      (corner_00),
    .corner_10_i      (corner_10),
    .corner_01_i      (corner_01),
    .corner_11_i      (corner_11),
    .offset_x_i       (offset_x),
    .offset_z_i       (offset_z),
    .restart_i        (restart),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .proxy_value_i    (proxy_value),
    .abs_error_i      (abs_error),
    .upper_triangle_i (upper_triangle),
    .max_error_i      (max_error),
    .squared_sum_i    (squared_sum),
    .sample_count_i   (sample_count),
    .pending_o        (pending),
    .fail_count_o     (fail_count),
    .result_count_o   (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: begin
        if (stall_left == 0) begin
          out_stall <= ~out_stall;
          stall_left = $urandom_range(1, 20);
        end else begin
          stall_left--;
        end
      end
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  function automatic logic signed [HB-1:0] near(input logic signed [HB-1:0] base, input int spread);
    return HB'(int'(base) + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic logic signed [HB-1:0] extreme();
    case ($urandom_range(0, 3))
      0: return H_MAX;
      1: return H_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic write_stride(input logic [STRIDE_BITS-1:0] value);
    logic ok;
    cfg_valid <= 1'b1;
    cfg_stride <= value;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic send_sample(input logic signed [HB-1:0] th, c00, c10, c01, c11,
                             input logic [OFS_BITS-1:0] dx, dz, input logic rs);
    int gap;
    logic ok;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    true_height <= th;
    corner_00 <= c00;
    corner_10 <= c10;
    corner_01 <= c01;
    corner_11 <= c11;
    offset_x <= dx;
    offset_z <= dz;
    restart <= rs;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    burst_left--;
    sent++;
  endtask

  task automatic end_phase();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic send_random(input int eff);
    logic signed [HB-1:0] base, th;
    logic signed [HB-1:0] c [4];
    logic [OFS_BITS-1:0] dx, dz;
    int spread;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        base = HB'($urandom);
        spread = 1 << $urandom_range(0, 14);
        foreach (c[i]) c[i] = near(base, spread);
        th = near(base, 2 * spread);
      end
      6, 7: begin
        foreach (c[i]) c[i] = HB'($urandom);
        th = HB'($urandom);
      end
      8: begin
        foreach (c[i]) c[i] = extreme();
        th = extreme();
      end
      default: begin
        foreach (c[i]) c[i] = ($urandom_range(0, 1) == 1) ? extreme() : HB'($urandom);
        th = HB'($urandom);
      end
    endcase
    if ($urandom_range(0, 99) < 85) begin
      dx = OFS_BITS'($urandom_range(0, eff - 1));
      dz = OFS_BITS'($urandom_range(0, eff - 1));
    end else begin
      dx = OFS_BITS'($urandom);
      dz = OFS_BITS'($urandom);
    end
    send_sample(th, c[0], c[1], c[2], c[3], dx, dz, $urandom_range(0, 19) == 0);
  endtask

  initial begin
    int stride_val, eff;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_max = 4;
    write_stride(STRIDE_BITS'(MAX_STRIDE));
    send_sample(0, 0, 0, 0, 0, 0, 0, 1'b1);
    send_sample(H_MIN, H_MAX, H_MAX, H_MAX, H_MAX, 0, 0, 1'b0);
    send_sample(H_MAX, H_MIN, H_MIN, H_MIN, H_MIN, 0, 0, 1'b0);
    send_sample(1000, 4096, -4096, 1024, 8191000, 255, 0, 1'b0);
    send_sample(-5000, -300, 700, -2100, 50, 0, 255, 1'b0);
    send_sample(H_MAX, H_MIN, H_MAX, H_MAX, H_MIN, 255, 255, 1'b0);
    send_sample(0, -7, 13, 29, -31, 128, 128, 1'b0);
    send_sample(0, -7, 13, 29, -31, 129, 128, 1'b0);
    send_sample(-3, -1, 0, 0, 0, 1, 0, 1'b0);
    send_sample(12345, 10, 20, 30, 40, 17, 90, 1'b1);
    end_phase();

    write_stride(1);
    send_sample(0, 100, 200, 300, 400, 0, 0, 1'b0);
    send_sample(0, 100, 200, 300, 400, 1, 0, 1'b0);
    send_sample(0, 100, 200, 300, 400, 1, 1, 1'b0);
    send_sample(0, 0, H_MAX, H_MIN, H_MAX, 255, 0, 1'b0);
    send_sample(0, 0, H_MIN, H_MAX, H_MIN, 255, 0, 1'b0);
    send_sample(H_MIN, H_MAX, H_MAX, H_MAX, H_MAX, 255, 255, 1'b0);
    end_phase();

    write_stride(0);
    send_sample(5, 9, -9, 3, -3, 0, 0, 1'b0);
    send_sample(5, 9, -9, 3, -3, 1, 0, 1'b0);
    end_phase();

    write_stride('1);
    send_sample(77, 1000, 2000, 3000, 4000, 255, 1, 1'b0);
    send_sample(77, 1000, 2000, 3000, 4000, 200, 100, 1'b1);
    end_phase();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: stride_val = MAX_STRIDE;
        1: stride_val = 1;
        2: stride_val = $urandom_range(2, 16);
        3: stride_val = 511;
        4: stride_val = 0;
        5: stride_val = $urandom_range(MAX_STRIDE + 1, 510);
        default: stride_val = $urandom_range(1, MAX_STRIDE);
      endcase
      gap_max = (ph % 3 == 1) ? 0 : $urandom_range(1, 12);
      write_stride(STRIDE_BITS'(stride_val));
      eff = (stride_val == 0) ? 1 : (stride_val > MAX_STRIDE) ? MAX_STRIDE : stride_val;
      repeat (85) send_random(eff);
      end_phase();
    end

    repeat (60) @(posedge clk);
    @(negedge clk);
    $display("Covered %0d samples over %0d stride settings, %0d output words compared.",
             sent, settings, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/hpes_pkg.sv
rtl/core/hpes_mac.sv
rtl/core/hpes_div.sv
rtl/core/hpes_stats.sv
rtl/core/heightmap_proxy_error_stats.sv
rtl/core/hpes_checker.sv
verif/heightmap_proxy_error_stats_checker.sv
verif/heightmap_proxy_error_stats_tb.sv
